FILE: rtl/euler_xyz_rotation_matrix_defines.svh
// Assertion macros shared by the rotation matrix RTL.
// Expects signals named clock and reset in the scope that uses them.
`ifndef EULER_XYZ_ROTATION_MATRIX_DEFINES_SVH
`define EULER_XYZ_ROTATION_MATRIX_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define EUL_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rotation matrix check failed");

// Next-cycle implication, also checked while reset is high.
`define EUL_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rotation matrix check failed");

`endif

FILE: rtl/eulxyz_pkg.sv
// Package for the Euler XYZ rotation matrix block: widths, types and the
// elaboration-time sine table generator. No dependencies.
`timescale 1ns / 1ps

package eulxyz_pkg;

   // Port widths fixed by the interface.
   localparam int IN_W  = 16;
   localparam int OUT_W = 16;

   // Number formats.
   localparam int ANGLE_BITS           = 16;
   localparam int COEF_FRAC_BITS       = 14;
   localparam int SINE_TABLE_ADDR_BITS = 10;

   localparam int PHASE_BITS = SINE_TABLE_ADDR_BITS + 2;
   localparam int QSTEPS     = 1 << SINE_TABLE_ADDR_BITS;
   localparam int ROM_AW     = SINE_TABLE_ADDR_BITS + 1;
   localparam int ROM_W      = COEF_FRAC_BITS + 1;
   localparam int S_W        = COEF_FRAC_BITS + 2;
   localparam int P_W        = 2 * S_W;
   localparam int SUM_W      = S_W + 1;

   // Table generator constants.
   localparam int          WORK_FRAC    = 30;
   localparam int          TAYLOR_TERMS = 10;
   localparam logic [63:0] HALF_PI_WORK = 64'd1686629713;

   // Pipeline depth from accepted word to result word.
   localparam int LATENCY = 7;

   typedef logic signed [S_W-1:0]   coef_type;
   typedef logic signed [SUM_W-1:0] entry_type;

   // Sines and cosines of the three angles.
   typedef struct packed {
      coef_type sx;
      coef_type cx;
      coef_type sy;
      coef_type cy;
      coef_type sz;
      coef_type cz;
   } trig_type;

   // First-level products that go straight into a matrix entry.
   typedef struct packed {
      coef_type cycz;
      coef_type cysz;
      coef_type cxsz;
      coef_type cxcz;
      coef_type sxcy;
      coef_type sxsz;
      coef_type sxcz;
      coef_type cxcy;
   } prod_type;

   // One quarter-wave entry: sin(pi/2 * k / QSTEPS) from a truncated Taylor
   // series, clamped to [0, 1] and rounded half up. Evaluated at elaboration.
   function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        s;
      logic [63:0]        one_work;
      logic [63:0]        half_down;
      logic signed [63:0] sum;
      int                 n;
      int                 down;
      down      = WORK_FRAC - COEF_FRAC_BITS;
      one_work  = 64'd1 << WORK_FRAC;
      half_down = (64'd1 << down) >> 1;
      x    = (HALF_PI_WORK * 64'(k) + 64'(QSTEPS / 2)) >> SINE_TABLE_ADDR_BITS;
      x2   = (x * x) >> WORK_FRAC;
      term = x;
      sum  = $signed(x);
      for (n = 1; n < TAYLOR_TERMS; n++) begin
         term = ((term * x2) >> WORK_FRAC) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if ($unsigned(sum) > one_work) begin
         sum = $signed(one_work);
      end
      s = $unsigned(sum);
      return ROM_W'((s + half_down) >> down);
   endfunction

   // Clamp a summed entry to plus or minus one.
   function automatic entry_type clamp_one(input entry_type v);
      entry_type one;
      one = entry_type'(1) <<< COEF_FRAC_BITS;
      if (v > one) begin
         return one;
      end else if (v < -one) begin
         return -one;
      end
      return v;
   endfunction

   // Two's complement bits of an entry at the port width.
   function automatic logic [OUT_W-1:0] pack_out(input entry_type v);
      logic signed [63:0] w;
      w = 64'(v);
      return w[OUT_W-1:0];
   endfunction

endpackage

FILE: rtl/eulxyz_sincos.sv
// Two-stage sine and cosine lookup for three binary angles.
// Depends on eulxyz_pkg for widths, the trig struct and the table generator.
`timescale 1ns / 1ps

module eulxyz_sincos import eulxyz_pkg::*; (
   input  logic              clock,
   input  logic [IN_W-1:0]   angle_x,
   input  logic [IN_W-1:0]   angle_y,
   input  logic [IN_W-1:0]   angle_z,
   output trig_type          trig
);

   logic [ROM_W-1:0]      sine_rom [QSTEPS+1];
   logic [IN_W-1:0]       angle    [3];
   logic [PHASE_BITS-1:0] phase    [6];
   logic [ROM_AW-1:0]     addr_in  [6];
   logic                  neg_in   [6];
   logic [ROM_AW-1:0]     addr_ff  [6];
   logic                  neg_ff   [6];
   coef_type              val_in   [6];
   coef_type              val_ff   [6];

   // Quarter-wave table, fixed at elaboration.
   for (genvar k = 0; k <= QSTEPS; k++) begin : g_rom
      assign sine_rom[k] = sine_entry(k);
   end

   assign angle[0] = angle_x;
   assign angle[1] = angle_y;
   assign angle[2] = angle_z;

   // Angle to phase: round to the phase grid, wrapping at a full turn.
   // Lane 2i is the sine, lane 2i+1 the cosine of axis i.
   for (genvar i = 0; i < 3; i++) begin : g_phase
      logic [ANGLE_BITS-1:0] a;
      assign a = ANGLE_BITS'(angle[i]);
      if (ANGLE_BITS >= PHASE_BITS) begin : g_down
         localparam int SH   = ANGLE_BITS - PHASE_BITS;
         localparam int HALF = (SH == 0) ? 0 : (1 << (SH - 1));
         logic [ANGLE_BITS:0] rnd;
         assign rnd = {1'b0, a} + (ANGLE_BITS + 1)'(HALF);
         assign phase[2*i] = PHASE_BITS'(rnd >> SH);
      end else begin : g_up
         localparam int SH = PHASE_BITS - ANGLE_BITS;
         assign phase[2*i] = PHASE_BITS'(a) << SH;
      end
      assign phase[2*i+1] = phase[2*i] + PHASE_BITS'(QSTEPS);
   end

   // Quadrant decode: odd quadrants read mirrored, the lower half negates.
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         if (phase[j][PHASE_BITS-2]) begin
            addr_in[j] = ROM_AW'(QSTEPS) -
                         ROM_AW'(phase[j][SINE_TABLE_ADDR_BITS-1:0]);
         end else begin
            addr_in[j] = ROM_AW'(phase[j][SINE_TABLE_ADDR_BITS-1:0]);
         end
         neg_in[j] = phase[j][PHASE_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 6; j++) begin
         addr_ff[j] <= addr_in[j];
         neg_ff[j]  <= neg_in[j];
      end
   end

   // Table read and sign.
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         if (neg_ff[j]) begin
            val_in[j] = -$signed(S_W'(sine_rom[addr_ff[j]]));
         end else begin
            val_in[j] = $signed(S_W'(sine_rom[addr_ff[j]]));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 6; j++) begin
         val_ff[j] <= val_in[j];
      end
   end

   assign trig.sx = val_ff[0];
   assign trig.cx = val_ff[1];
   assign trig.sy = val_ff[2];
   assign trig.cy = val_ff[3];
   assign trig.sz = val_ff[4];
   assign trig.cz = val_ff[5];

endmodule

FILE: rtl/eulxyz_mulrnd.sv
// Two-stage fixed-point multiplier with round half away from zero.
// Depends on eulxyz_pkg for the coefficient and product widths.
`timescale 1ns / 1ps

module eulxyz_mulrnd import eulxyz_pkg::*; (
   input  logic     clock,
   input  coef_type a,
   input  coef_type b,
   output coef_type r
);

   logic signed [P_W-1:0] prod_ff;
   logic [P_W-1:0]        mag;
   logic [P_W-1:0]        rnd;
   coef_type              r_in;
   coef_type              r_ff;

   // Full product.
   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   // Round the magnitude, then restore the sign.
   always_comb begin
      mag = prod_ff[P_W-1] ? $unsigned(-prod_ff) : $unsigned(prod_ff);
      rnd = (mag + (P_W'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
      if (prod_ff[P_W-1]) begin
         r_in = -$signed(S_W'(rnd));
      end else begin
         r_in = $signed(S_W'(rnd));
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end

   assign r = r_ff;

endmodule

FILE: rtl/euler_xyz_rotation_matrix.sv
// Top level of the Euler XYZ rotation matrix: sin/cos lookup, two product
// levels and the entry sum with clamp. Depends on eulxyz_pkg, eulxyz_sincos,
// eulxyz_mulrnd and the assertion macro header.
//
//   channel   ports                              handshake
//   -------   --------------------------------   -------------------------------
//   request   req_angle_x, req_angle_y, _z       req_start while busy is low
//   response  rsp_m_00 .. rsp_m_22               rsp_strobe, one cycle per word
//
// A word can enter every cycle while busy is low. Its result is registered through
// the chain: two lookup stages, two multiplier levels of two stages each, and
// one sum-and-clamp stage.
// Reset is synchronous and clears the valid chain; busy is high only in reset.
// The receiver takes every result word as it comes, so nothing ever stalls.
`timescale 1ns / 1ps

`include "euler_xyz_rotation_matrix_defines.svh"

module euler_xyz_rotation_matrix import eulxyz_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_start,
   input  logic [IN_W-1:0]  req_angle_x,
   input  logic [IN_W-1:0]  req_angle_y,
   input  logic [IN_W-1:0]  req_angle_z,
   output logic             busy,
   output logic             rsp_strobe,
   output logic [OUT_W-1:0] rsp_m_00,
   output logic [OUT_W-1:0] rsp_m_01,
   output logic [OUT_W-1:0] rsp_m_02,
   output logic [OUT_W-1:0] rsp_m_10,
   output logic [OUT_W-1:0] rsp_m_11,
   output logic [OUT_W-1:0] rsp_m_12,
   output logic [OUT_W-1:0] rsp_m_20,
   output logic [OUT_W-1:0] rsp_m_21,
   output logic [OUT_W-1:0] rsp_m_22
);

   logic               accept;
   logic [LATENCY-1:0] valid_in;
   logic [LATENCY-1:0] valid_ff;

   trig_type  trig;
   coef_type  sxsy;
   coef_type  cxsy;
   prod_type  prod;
   prod_type  prod_ff [2];
   coef_type  sz_ff   [2];
   coef_type  cz_ff   [2];
   coef_type  sy_ff   [4];
   coef_type  sxsycz;
   coef_type  sxsysz;
   coef_type  cxsycz;
   coef_type  cxsysz;
   entry_type m_in    [9];
   entry_type m_ff    [9];

   assign busy   = reset;
   assign accept = req_start && !busy;

   // Valid bits run alongside the data pipeline.
   assign valid_in = {valid_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stages 1 and 2: sines and cosines.
   eulxyz_sincos u_sincos (
      .clock   (clock),
      .angle_x (req_angle_x),
      .angle_y (req_angle_y),
      .angle_z (req_angle_z),
      .trig    (trig)
   );

   // Stages 3 and 4: first-level products.
   eulxyz_mulrnd u_sxsy (.clock(clock), .a(trig.sx), .b(trig.sy), .r(sxsy));
   eulxyz_mulrnd u_cxsy (.clock(clock), .a(trig.cx), .b(trig.sy), .r(cxsy));
   eulxyz_mulrnd u_cycz (.clock(clock), .a(trig.cy), .b(trig.cz), .r(prod.cycz));
   eulxyz_mulrnd u_cysz (.clock(clock), .a(trig.cy), .b(trig.sz), .r(prod.cysz));
   eulxyz_mulrnd u_cxsz (.clock(clock), .a(trig.cx), .b(trig.sz), .r(prod.cxsz));
   eulxyz_mulrnd u_cxcz (.clock(clock), .a(trig.cx), .b(trig.cz), .r(prod.cxcz));
   eulxyz_mulrnd u_sxcy (.clock(clock), .a(trig.sx), .b(trig.cy), .r(prod.sxcy));
   eulxyz_mulrnd u_sxsz (.clock(clock), .a(trig.sx), .b(trig.sz), .r(prod.sxsz));
   eulxyz_mulrnd u_sxcz (.clock(clock), .a(trig.sx), .b(trig.cz), .r(prod.sxcz));
   eulxyz_mulrnd u_cxcy (.clock(clock), .a(trig.cx), .b(trig.cy), .r(prod.cxcy));

   // Delay lines that keep the operands aligned with the product levels.
   always_ff @(posedge clock) begin
      sz_ff[0]   <= trig.sz;
      sz_ff[1]   <= sz_ff[0];
      cz_ff[0]   <= trig.cz;
      cz_ff[1]   <= cz_ff[0];
      sy_ff[0]   <= trig.sy;
      sy_ff[1]   <= sy_ff[0];
      sy_ff[2]   <= sy_ff[1];
      sy_ff[3]   <= sy_ff[2];
      prod_ff[0] <= prod;
      prod_ff[1] <= prod_ff[0];
   end

   // Stages 5 and 6: second-level products through the shared sy terms.
   eulxyz_mulrnd u_sxsycz (.clock(clock), .a(sxsy), .b(cz_ff[1]), .r(sxsycz));
   eulxyz_mulrnd u_sxsysz (.clock(clock), .a(sxsy), .b(sz_ff[1]), .r(sxsysz));
   eulxyz_mulrnd u_cxsycz (.clock(clock), .a(cxsy), .b(cz_ff[1]), .r(cxsycz));
   eulxyz_mulrnd u_cxsysz (.clock(clock), .a(cxsy), .b(sz_ff[1]), .r(cxsysz));

   // Stage 7: entry sums and clamp to plus or minus one.
   always_comb begin
      m_in[0] = clamp_one(SUM_W'(prod_ff[1].cycz));
      m_in[1] = clamp_one(-SUM_W'(prod_ff[1].cysz));
      m_in[2] = clamp_one(SUM_W'(sy_ff[3]));
      m_in[3] = clamp_one(SUM_W'(sxsycz) + SUM_W'(prod_ff[1].cxsz));
      m_in[4] = clamp_one(SUM_W'(prod_ff[1].cxcz) - SUM_W'(sxsysz));
      m_in[5] = clamp_one(-SUM_W'(prod_ff[1].sxcy));
      m_in[6] = clamp_one(SUM_W'(prod_ff[1].sxsz) - SUM_W'(cxsycz));
      m_in[7] = clamp_one(SUM_W'(cxsysz) + SUM_W'(prod_ff[1].sxcz));
      m_in[8] = clamp_one(SUM_W'(prod_ff[1].cxcy));
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 9; j++) begin
         m_ff[j] <= m_in[j];
      end
   end

   assign rsp_strobe = valid_ff[LATENCY-1];
   assign rsp_m_00   = pack_out(m_ff[0]);
   assign rsp_m_01   = pack_out(m_ff[1]);
   assign rsp_m_02   = pack_out(m_ff[2]);
   assign rsp_m_10   = pack_out(m_ff[3]);
   assign rsp_m_11   = pack_out(m_ff[4]);
   assign rsp_m_12   = pack_out(m_ff[5]);
   assign rsp_m_20   = pack_out(m_ff[6]);
   assign rsp_m_21   = pack_out(m_ff[7]);
   assign rsp_m_22   = pack_out(m_ff[8]);

   // Every accepted word yields exactly one result word, a fixed time later.
   `EUL_ASSERT_IMP(a_fwd_latency, accept, ##LATENCY rsp_strobe)
   `EUL_ASSERT_IMP(a_bwd_latency, rsp_strobe, $past(accept, LATENCY))
   // Reset empties the pipeline.
   `EUL_ASSERT_NXT(a_reset_flush, reset, !rsp_strobe)
   // The mixed entry m_11 stays inside the unit range after the clamp.
   `EUL_ASSERT_IMP(a_clamp_range, rsp_strobe,
      (m_ff[4] <= (entry_type'(1) <<< COEF_FRAC_BITS)) &&
      (m_ff[4] >= -(entry_type'(1) <<< COEF_FRAC_BITS)))

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for euler_xyz_rotation_matrix: drives angle triples and
// checks all nine matrix entries against a behavioral predictor in this file.
// Depends on eulxyz_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_top;
   import eulxyz_pkg::*;

   localparam int  HALF_PERIOD  = 10;
   localparam int  CYCLE_LIMIT  = 100000;
   localparam int  WORDS_PER_PHASE = 340;
   localparam logic [15:0] PLUS_ONE  = 16'sd16384;
   localparam logic [15:0] MINUS_ONE = -16'sd16384;

   // Nine entries, index 0 is m_00 and index 8 is m_22.
   typedef logic [8:0][OUT_W-1:0] matrix_type;

   typedef struct packed {
      logic [IN_W-1:0] ax;
      logic [IN_W-1:0] ay;
      logic [IN_W-1:0] az;
      logic            fixed_answer;
      matrix_type      answer;
   } angle_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_start;
   logic [IN_W-1:0]  req_angle_x;
   logic [IN_W-1:0]  req_angle_y;
   logic [IN_W-1:0]  req_angle_z;
   logic             busy;
   logic             rsp_strobe;
   logic [OUT_W-1:0] rsp_m_00, rsp_m_01, rsp_m_02;
   logic [OUT_W-1:0] rsp_m_10, rsp_m_11, rsp_m_12;
   logic [OUT_W-1:0] rsp_m_20, rsp_m_21, rsp_m_22;

   matrix_type       pending_matrices[$];
   angle_row_type    angle_rows[$];
   longint           quarter_wave[0:QSTEPS];
   int               error_count = 0;
   int               cycle_count = 0;

   euler_xyz_rotation_matrix uut (
      .clock       (clock),
      .reset       (reset),
      .req_start   (req_start),
      .req_angle_x (req_angle_x),
      .req_angle_y (req_angle_y),
      .req_angle_z (req_angle_z),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .rsp_m_00    (rsp_m_00),
      .rsp_m_01    (rsp_m_01),
      .rsp_m_02    (rsp_m_02),
      .rsp_m_10    (rsp_m_10),
      .rsp_m_11    (rsp_m_11),
      .rsp_m_12    (rsp_m_12),
      .rsp_m_20    (rsp_m_20),
      .rsp_m_21    (rsp_m_21),
      .rsp_m_22    (rsp_m_22)
   );

   always #HALF_PERIOD clock = ~clock;

   // Quarter-wave sine entry from a truncated Taylor series in 30-bit fixed point.
   function automatic longint quarter_wave_entry(input int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned one_work;
      longint          sum;
      int              n;
      int              down;
      down     = 30 - COEF_FRAC_BITS;
      one_work = 64'd1 << 30;
      x        = (HALF_PI_WORK * 64'(k) + 64'(QSTEPS / 2)) >> SINE_TABLE_ADDR_BITS;
      x2       = (x * x) >> 30;
      term     = x;
      sum      = longint'(x);
      for (n = 1; n < 10; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (longint'(one_work) < sum) begin
         sum = longint'(one_work);
      end
      return (sum + ((longint'(1) << down) >>> 1)) >>> down;
   endfunction

   // Angle rounded half up to the phase resolution, wrapping at a full turn.
   function automatic longint unsigned phase_of_angle(input logic [IN_W-1:0] a);
      longint unsigned av;
      int              sh;
      av = 64'(a) & ((64'd1 << ANGLE_BITS) - 1);
      if (ANGLE_BITS >= PHASE_BITS) begin
         sh = ANGLE_BITS - PHASE_BITS;
         av = (av + ((64'd1 << sh) >> 1)) >> sh;
      end else begin
         av = av << (PHASE_BITS - ANGLE_BITS);
      end
      return av & ((64'd1 << PHASE_BITS) - 1);
   endfunction

   // Odd quadrants read the table mirrored; the lower half-turn is negated.
   function automatic longint sine_of_phase(input longint unsigned p);
      longint unsigned q;
      longint unsigned r;
      longint          v;
      q = (p >> SINE_TABLE_ADDR_BITS) & 64'd3;
      r = p & 64'(QSTEPS - 1);
      v = q[0] ? quarter_wave[QSTEPS - int'(r)] : quarter_wave[int'(r)];
      return q[1] ? -v : v;
   endfunction

   // Product of two coefficients, rounded half away from zero.
   function automatic longint rounded_product(input longint a, input longint b);
      longint p;
      longint mag;
      longint r;
      p   = a * b;
      mag = (p < 0) ? -p : p;
      r   = (mag + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      return (p < 0) ? -r : r;
   endfunction

   function automatic logic [OUT_W-1:0] clamped_entry(input longint v);
      longint one;
      one = longint'(1) <<< COEF_FRAC_BITS;
      if (v > one) begin
         v = one;
      end
      if (v < -one) begin
         v = -one;
      end
      return v[OUT_W-1:0];
   endfunction

   // Closed-form Rx*Ry*Rz for one angle triple.
   function automatic matrix_type rotation_of(input logic [IN_W-1:0] ax,
                                              input logic [IN_W-1:0] ay,
                                              input logic [IN_W-1:0] az);
      longint     sx, cx, sy, cy, sz, cz, sxsy, cxsy;
      matrix_type m;
      sx   = sine_of_phase(phase_of_angle(ax));
      cx   = sine_of_phase(phase_of_angle(ax) + QSTEPS);
      sy   = sine_of_phase(phase_of_angle(ay));
      cy   = sine_of_phase(phase_of_angle(ay) + QSTEPS);
      sz   = sine_of_phase(phase_of_angle(az));
      cz   = sine_of_phase(phase_of_angle(az) + QSTEPS);
      sxsy = rounded_product(sx, sy);
      cxsy = rounded_product(cx, sy);
      m[0] = clamped_entry(rounded_product(cy, cz));
      m[1] = clamped_entry(-rounded_product(cy, sz));
      m[2] = clamped_entry(sy);
      m[3] = clamped_entry(rounded_product(sxsy, cz) + rounded_product(cx, sz));
      m[4] = clamped_entry(rounded_product(cx, cz) - rounded_product(sxsy, sz));
      m[5] = clamped_entry(-rounded_product(sx, cy));
      m[6] = clamped_entry(rounded_product(sx, sz) - rounded_product(cxsy, cz));
      m[7] = clamped_entry(rounded_product(cxsy, sz) + rounded_product(sx, cz));
      m[8] = clamped_entry(rounded_product(cx, cy));
      return m;
   endfunction

   task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want,
                                  input logic [OUT_W-1:0] got);
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what,
               $signed(want), $signed(got));
      error_count++;
   endtask

   task automatic add_row(input logic [IN_W-1:0] ax, input logic [IN_W-1:0] ay,
                          input logic [IN_W-1:0] az, input logic fixed_answer,
                          input matrix_type answer);
      angle_row_type row;
      row.ax           = ax;
      row.ay           = ay;
      row.az           = az;
      row.fixed_answer = fixed_answer;
      row.answer       = answer;
      angle_rows.push_back(row);
   endtask

   // Angles biased toward quarter turns, phase rounding edges and the wrap.
   function automatic logic [IN_W-1:0] pick_angle();
      int mode;
      mode = $urandom_range(9);
      case (mode)
         6: begin
            return 16'(($urandom_range(3) << 14) + $urandom_range(18) - 9);
         end
         7: begin
            return {16'($urandom)} & 16'hFFF0 | ($urandom_range(1) ? 16'h7 : 16'h8);
         end
         8: begin
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   // One word is offered, after random idle cycles with junk on the angles,
   // and held until the block takes it.
   task automatic drive_word(input logic [IN_W-1:0] ax, input logic [IN_W-1:0] ay,
                             input logic [IN_W-1:0] az, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_start   <= 1'b0;
         req_angle_x <= 16'($urandom);
         req_angle_y <= 16'($urandom);
         req_angle_z <= 16'($urandom);
         @(posedge clock);
      end
      req_start   <= 1'b1;
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Result checker: every strobed word is compared with the oldest expectation.
   always @(posedge clock) begin
      matrix_type got;
      matrix_type want;
      got = {rsp_m_22, rsp_m_21, rsp_m_20, rsp_m_12, rsp_m_11, rsp_m_10,
             rsp_m_02, rsp_m_01, rsp_m_00};
      if (!reset && rsp_strobe) begin
         if (pending_matrices.size() == 0) begin
            report_mismatch("unexpected result word", '0, got[0]);
         end else begin
            want = pending_matrices.pop_front();
            for (int i = 0; i < 9; i++) begin
               if (got[i] !== want[i]) begin
                  report_mismatch($sformatf("m_%0d%0d", i / 3, i % 3), want[i], got[i]);
               end
            end
         end
      end
   end

   // Stimulus.
   initial begin
      matrix_type identity;
      matrix_type fixed;
      int         idle_pcts[4];
      logic [IN_W-1:0] ax, ay, az;

      reset       <= 1'b1;
      req_start   <= 1'b0;
      req_angle_x <= '0;
      req_angle_y <= '0;
      req_angle_z <= '0;
      for (int k = 0; k <= QSTEPS; k++) begin
         quarter_wave[k] = quarter_wave_entry(k);
      end

      // Directed rows; obvious matrices are typed in, the rest predicted.
      identity    = '0;
      identity[0] = PLUS_ONE;
      identity[4] = PLUS_ONE;
      identity[8] = PLUS_ONE;
      add_row(16'h0000, 16'h0000, 16'h0000, 1'b1, identity);
      add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, identity);
      add_row(16'hFFF8, 16'hFFF8, 16'hFFF8, 1'b1, identity);
      fixed = identity;
      fixed[4] = MINUS_ONE;
      fixed[8] = MINUS_ONE;
      add_row(16'h8000, 16'h0000, 16'h0000, 1'b1, fixed);
      fixed = '0;
      fixed[2] = PLUS_ONE;
      fixed[4] = PLUS_ONE;
      fixed[6] = MINUS_ONE;
      add_row(16'h0000, 16'h4000, 16'h0000, 1'b1, fixed);
      fixed = '0;
      fixed[1] = MINUS_ONE;
      fixed[3] = PLUS_ONE;
      fixed[8] = PLUS_ONE;
      add_row(16'h0000, 16'h0000, 16'h4000, 1'b1, fixed);
      fixed = '0;
      fixed[0] = PLUS_ONE;
      fixed[5] = MINUS_ONE;
      fixed[7] = PLUS_ONE;
      add_row(16'h4000, 16'h0000, 16'h0000, 1'b1, fixed);
      add_row(16'hC000, 16'hC000, 16'hC000, 1'b0, '0);
      add_row(16'hFFF7, 16'hFFF7, 16'hFFF7, 1'b0, '0);
      add_row(16'h0007, 16'h0008, 16'h0017, 1'b0, '0);
      add_row(16'h2000, 16'h2000, 16'h2000, 1'b0, '0);
      add_row(16'hE000, 16'h6000, 16'hA000, 1'b0, '0);
      add_row(16'h1234, 16'h4000, 16'h5678, 1'b0, '0);
      add_row(16'h9ABC, 16'hC000, 16'h0DEF, 1'b0, '0);
      add_row(16'h7FFF, 16'h8008, 16'h7FF8, 1'b0, '0);
      add_row(16'h3FF7, 16'h4008, 16'hBFF8, 1'b0, '0);
      add_row(16'h5555, 16'hAAAA, 16'h5555, 1'b0, '0);
      add_row(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, '0);
      add_row(16'h1000, 16'h3000, 16'h5000, 1'b0, '0);
      add_row(16'h6C00, 16'hF400, 16'h2A00, 1'b0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (angle_rows[i]) begin
         drive_word(angle_rows[i].ax, angle_rows[i].ay, angle_rows[i].az, 0);
         if (angle_rows[i].fixed_answer) begin
            pending_matrices.push_back(angle_rows[i].answer);
         end else begin
            pending_matrices.push_back(rotation_of(angle_rows[i].ax, angle_rows[i].ay,
                                                   angle_rows[i].az));
         end
      end

      // Random words in phases of different sender idling.
      idle_pcts = '{0, 46, 0, 32};
      foreach (idle_pcts[p]) begin
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            ax = pick_angle();
            ay = pick_angle();
            az = pick_angle();
            drive_word(ax, ay, az, idle_pcts[p]);
            pending_matrices.push_back(rotation_of(ax, ay, az));
         end
      end
      req_start <= 1'b0;

      // Drain, then wait longer than the pipeline depth for stray words.
      while (pending_matrices.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/eulxyz_pkg.sv
rtl/eulxyz_sincos.sv
rtl/eulxyz_mulrnd.sv
rtl/euler_xyz_rotation_matrix.sv
bench/tb_top.sv
